FILE: rtl/core/vtx_pkg.sv
// ----------------------------------------------------------------------------
// vtx_pkg: shared types and constants for the 4x4 vertex transform
// Modes, register layout and the transaction carried from front to back.
// ----------------------------------------------------------------------------
package vtx_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 64;
  localparam int QUEUE_DEPTH   = 8;
  localparam int FRONT_STAGES  = 4;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_PERSP  = 2'd2,
    MODE_NORMAL = 2'd3
  } mode_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] matrix_t;

  // Rounded, saturated components of one vertex, before the divide.
  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               sat;
  } vtx_item_t;

endpackage

FILE: rtl/core/vtx_front.sv
// ----------------------------------------------------------------------------
// vtx_front: multiply and round
// Registers the vertex, forms the sixteen products, sums them in a registered
// tree, then rounds and saturates each component.
// ----------------------------------------------------------------------------
module vtx_front #(
  parameter int FRAC_BITS = vtx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         mode,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [31:0] in_w,
  input  vtx_pkg::matrix_t   matrix,
  output logic               item_valid,
  output vtx_pkg::vtx_item_t item
);
  import vtx_pkg::*;

  localparam logic signed [31:0] ONE_Q = 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [65:0] BIAS  = 66'(66'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [65:0] S_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S_MIN = -66'sd2147483648;

  logic               vld1, vld2, vld3;
  mode_t              mode1, mode2, mode3;
  logic signed [31:0] v1 [4];
  logic signed [63:0] prod [4][4];
  logic signed [64:0] pair [4][2];
  logic signed [31:0] res_next [4];
  logic [3:0]         sat_next;

  // Stage 1: register the vertex, forcing w by mode
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
    mode1 <= mode_t'(mode);
    v1[0] <= in_x;
    v1[1] <= in_y;
    v1[2] <= in_z;
    case (mode_t'(mode))
      MODE_FULL:   v1[3] <= in_w;
      MODE_NORMAL: v1[3] <= '0;
      default:     v1[3] <= ONE_Q;
    endcase
  end

  // Stage 2: sixteen products, element (i, j) from register {i, j[1]}
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
    mode2 <= mode1;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        prod[j][i] <= v1[i] * $signed(matrix[i*2 + j/2][(j%2)*32 +: 32]);
      end
    end
  end

  // Stage 3: pairwise sums
  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
    mode3 <= mode2;
    for (int j = 0; j < 4; j++) begin
      pair[j][0] <= 65'(prod[j][0]) + 65'(prod[j][1]);
      pair[j][1] <= 65'(prod[j][2]) + 65'(prod[j][3]);
    end
  end

  // Stage 4: final sum, round half up, saturate
  always_comb begin
    logic signed [65:0] s;
    logic signed [65:0] sh;
    for (int j = 0; j < 4; j++) begin
      s  = 66'(pair[j][0]) + 66'(pair[j][1]) + BIAS;
      sh = s >>> FRAC_BITS;
      sat_next[j] = 1'b0;
      if (sh > S_MAX) begin
        res_next[j] = 32'sh7fff_ffff;
        sat_next[j] = 1'b1;
      end else if (sh < S_MIN) begin
        res_next[j] = 32'sh8000_0000;
        sat_next[j] = 1'b1;
      end else begin
        res_next[j] = sh[31:0];
      end
    end
    // normals drop the fourth column altogether
    if (mode3 == MODE_NORMAL) begin
      res_next[3] = '0;
      sat_next[3] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= vld3;
    end
    item.mode <= mode3;
    item.x    <= res_next[0];
    item.y    <= res_next[1];
    item.z    <= res_next[2];
    item.w    <= res_next[3];
    item.sat  <= |sat_next;
  end

endmodule

FILE: rtl/core/vtx_queue.sv
// ----------------------------------------------------------------------------
// vtx_queue: transaction queue between front and back
// Small circular buffer with a fill count.
// ----------------------------------------------------------------------------
module vtx_queue #(
  parameter int DEPTH = vtx_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  vtx_pkg::vtx_item_t         push_item,
  input  logic                       pop,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output vtx_pkg::vtx_item_t         head
);
  import vtx_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  vtx_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: rtl/core/vtx_divider.sv
// ----------------------------------------------------------------------------
// vtx_divider: perspective divide and result register
// Pipelined restoring divider, one quotient bit per stage for x, y and z,
// followed by sign fix-up, saturation and the output register.
// ----------------------------------------------------------------------------
module vtx_divider #(
  parameter int FRAC_BITS = vtx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vtx_pkg::vtx_item_t in_item,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic               saturated,
  output logic               w_zero
);
  import vtx_pkg::*;

  localparam int NB = VAL_W + FRAC_BITS;
  localparam logic [NB-1:0] Q_LIM = NB'(64'h8000_0000);

  typedef struct packed {
    logic                 vld;
    vtx_item_t            item;
    logic [31:0]          dmag;
    logic [2:0]           neg;
    logic [2:0][31:0]     rem;
    logic [2:0][NB-1:0]   num;
  } div_stage_t;

  div_stage_t pipe [NB+1];
  div_stage_t prep;
  logic [2:0][31:0] comp;

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    mag32 = a[31] ? 32'(-a) : 32'(a);
  endfunction

  // Set-up: magnitudes and quotient signs; reset clears the valid bit
  always_comb begin
    comp[0] = in_item.x;
    comp[1] = in_item.y;
    comp[2] = in_item.z;
    prep.vld  = in_valid && !rst;
    prep.item = in_item;
    prep.dmag = mag32(in_item.w);
    for (int l = 0; l < 3; l++) begin
      prep.neg[l] = comp[l][31] ^ in_item.w[31];
      prep.rem[l] = '0;
      prep.num[l] = NB'({mag32(comp[l]), {FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    pipe[0] <= prep;
  end

  for (genvar s = 0; s < NB; s++) begin : g_step
    div_stage_t nxt;

    always_comb begin
      logic [32:0] t;
      logic [32:0] diff;
      nxt = pipe[s];
      nxt.vld = pipe[s].vld && !rst;
      for (int l = 0; l < 3; l++) begin
        t    = {pipe[s].rem[l], pipe[s].num[l][NB-1]};
        diff = t - {1'b0, pipe[s].dmag};
        if (t >= {1'b0, pipe[s].dmag}) begin
          nxt.rem[l] = diff[31:0];
          nxt.num[l] = {pipe[s].num[l][NB-2:0], 1'b1};
        end else begin
          nxt.rem[l] = t[31:0];
          nxt.num[l] = {pipe[s].num[l][NB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      pipe[s+1] <= nxt;
    end
  end

  // Fix up signs, saturate, pick divided or plain components
  logic signed [31:0] quo [3];
  logic [2:0]         qsat;
  div_stage_t         last;

  assign last = pipe[NB];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qsat[l] = 1'b0;
      if (last.neg[l]) begin
        if (last.num[l] > Q_LIM) begin
          quo[l]  = 32'sh8000_0000;
          qsat[l] = 1'b1;
        end else begin
          quo[l] = 32'(-last.num[l]);
        end
      end else begin
        if (last.num[l] >= Q_LIM) begin
          quo[l]  = 32'sh7fff_ffff;
          qsat[l] = 1'b1;
        end else begin
          quo[l] = last.num[l][31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.vld;
    end
    if (last.item.mode == MODE_PERSP) begin
      out_w <= '0;
      if (last.item.w == '0) begin
        out_x     <= '0;
        out_y     <= '0;
        out_z     <= '0;
        saturated <= 1'b0;
        w_zero    <= 1'b1;
      end else begin
        out_x     <= quo[0];
        out_y     <= quo[1];
        out_z     <= quo[2];
        saturated <= last.item.sat | (|qsat);
        w_zero    <= 1'b0;
      end
    end else begin
      out_x     <= last.item.x;
      out_y     <= last.item.y;
      out_z     <= last.item.z;
      out_w     <= last.item.w;
      saturated <= last.item.sat;
      w_zero    <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/vertex_transform_4x4.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4: homogeneous 4x4 vertex transform, row-vector form
// Front multiplies and rounds, a queue decouples it from the divide and
// output stage.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  vertex   | start, busy      | mode, in_x, in_y, in_z, in_w
//  result   | done (strobe)    | out_x, out_y, out_z, out_w, saturated, w_zero
//  config   | cfg_we           | cfg_index, cfg_data
//
// One vertex a cycle while busy is low; the path holds 4 front stages, 1 queue,
// 1 set-up, (32 + FRAC_BITS) divider stages and 1 output register in every mode.
// The divider depth sets the latency; every stage advances each cycle.
// Synchronous reset restores the identity matrix and empties all stages.
// Results cannot be stalled; busy rises at QUEUE_DEPTH - FRONT_STAGES queued items.
// ----------------------------------------------------------------------------
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vtx_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic signed [31:0]              in_x,
  input  logic signed [31:0]              in_y,
  input  logic signed [31:0]              in_z,
  input  logic signed [31:0]              in_w,
  output logic                            done,
  output logic signed [31:0]              out_x,
  output logic signed [31:0]              out_y,
  output logic signed [31:0]              out_z,
  output logic signed [31:0]              out_w,
  output logic                            saturated,
  output logic                            w_zero,
  input  logic                            cfg_we,
  input  logic [vtx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vtx_pkg::CFG_W-1:0]       cfg_data
);
  import vtx_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(64'd1 << (FRAC_BITS + 32));
  localparam matrix_t MATRIX_RST = {ONE_HI, CFG_W'(0), ONE_LO, CFG_W'(0),
                                    CFG_W'(0), ONE_HI, CFG_W'(0), ONE_LO};

  matrix_t    matrix;
  logic       accept;
  logic       f_valid;
  vtx_item_t  f_item;
  logic       q_empty, q_full, q_pop;
  logic [CNT_W-1:0] q_count;
  vtx_item_t  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= MATRIX_RST;
    end else if (cfg_we) begin
      matrix[cfg_index] <= cfg_data;
    end
  end

  // hold off new vertices while the queue could not absorb the front's contents
  assign busy   = (q_count >= CNT_W'(QUEUE_DEPTH - FRONT_STAGES));
  assign accept = start && !busy;
  assign q_pop  = !q_empty;

  vtx_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (mode),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .in_w       (in_w),
    .matrix     (matrix),
    .item_valid (f_valid),
    .item       (f_item)
  );

  vtx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count),
    .head      (q_head)
  );

  vtx_divider #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_pop),
    .in_item   (q_head),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_w     (out_w),
    .saturated (saturated),
    .w_zero    (w_zero)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_valid && q_full))
    else $error("transaction pushed into full queue");

  a_wz_excl: assert property (@(posedge clk) disable iff (rst)
    done && w_zero |-> !saturated && out_x == '0 && out_y == '0 && out_z == '0)
    else $error("zero-w result not cleared");

  a_wz_w: assert property (@(posedge clk) disable iff (rst)
    done && w_zero |-> out_w == '0)
    else $error("out_w set on zero-w result");

endmodule
